>>> design/rgbhsb_pkg.sv
// Shared widths, constants and codes for the RGB to hue/saturation/brightness converter.
package rgbhsb_pkg;

  // Divider datapath: quotient bits resolved one per stage
  localparam int DIV_Q_W    = 24;
  localparam int DIV_DEN_W  = 24;
  localparam int DIV_NUM_W  = DIV_Q_W + DIV_DEN_W;
  localparam int DIV_STEPS  = DIV_Q_W;
  localparam int CHAN_W     = 24;
  localparam int DIV_SIDE_W = CHAN_W + 4;

  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int HUE_W      = 16;
  localparam int SAT_W      = 17;
  localparam int HQ_W       = 13;
  localparam int PROD_W     = CHAN_W + HQ_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MAX  = 2'd2;

  localparam logic [CFG_W-1:0]  CHAN_MAX_RESET = 10'd255;
  localparam logic [HQ_W-1:0]   HUE_SIXTY      = 13'd7680;
  localparam logic [HUE_W:0]    HUE_GREEN_OFS  = 17'd15360;
  localparam logic [HUE_W:0]    HUE_BLUE_OFS   = 17'd30720;
  localparam logic [HUE_W:0]    HUE_FULL       = 17'd46080;

  typedef enum logic [1:0] {
    BR_RED,
    BR_GREEN,
    BR_BLUE
  } branch_t;

endpackage

>>> design/rgb_to_hsb_convert_core.sv
// Top level: RGB pixel to hue, saturation and brightness, fully pipelined.
// An accepted request passes three channel dividers, stages M1-M4, hue/sat dividers and F1-F2.
// Throughput: one request per cycle; two 24-stage bit-per-cycle divider chains set the depth.
// A stalled result is parked in a one-entry skid register, which then holds the pipeline.
// Reset (rst, synchronous) clears all valid bits and the skid, and sets each channel max to 255.
module rgb_to_hsb_convert_core import rgbhsb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [CHAN_W-1:0]    rgb_color,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [HUE_W-1:0]     hue_degrees,
  output logic [SAT_W-1:0]     saturation_level,
  output logic [CHAN_W-1:0]    brightness_level
);

  logic [CFG_W-1:0] red_max;
  logic [CFG_W-1:0] green_max;
  logic [CFG_W-1:0] blue_max;

  logic en;
  logic skid_full;
  logic acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_max   <= CHAN_MAX_RESET;
      green_max <= CHAN_MAX_RESET;
      blue_max  <= CHAN_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RED_MAX:   red_max   <= cfg_data;
        CFG_GREEN_MAX: green_max <= cfg_data;
        CFG_BLUE_MAX:  blue_max  <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign en        = !skid_full;
  assign pix_stall = skid_full;
  assign acc       = pix_valid && en;

  // Normalize each byte: byte * 65536 / max, zero max treated as one
  logic [DIV_DEN_W-1:0] red_den, green_den, blue_den;
  assign red_den   = (red_max == '0)   ? DIV_DEN_W'(1) : DIV_DEN_W'(red_max);
  assign green_den = (green_max == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(green_max);
  assign blue_den  = (blue_max == '0)  ? DIV_DEN_W'(1) : DIV_DEN_W'(blue_max);

  logic                  nr_valid, ng_valid, nb_valid;
  logic [DIV_Q_W-1:0]    nr, ng, nb;
  logic [DIV_SIDE_W-1:0] nr_side, ng_side, nb_side;

  rgbhsb_div u_div_red (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (acc),
    .dividend  ({24'd0, rgb_color[23:16], 16'd0}),
    .divisor   (red_den),
    .side_in   ('0),
    .out_valid (nr_valid),
    .quotient  (nr),
    .side_out  (nr_side)
  );

  rgbhsb_div u_div_green (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (acc),
    .dividend  ({24'd0, rgb_color[15:8], 16'd0}),
    .divisor   (green_den),
    .side_in   ('0),
    .out_valid (ng_valid),
    .quotient  (ng),
    .side_out  (ng_side)
  );

  rgbhsb_div u_div_blue (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (acc),
    .dividend  ({24'd0, rgb_color[7:0], 16'd0}),
    .divisor   (blue_den),
    .side_in   ('0),
    .out_valid (nb_valid),
    .quotient  (nb),
    .side_out  (nb_side)
  );

  // Stage M1: largest, smallest, hue branch
  logic              m1_valid;
  logic [CHAN_W-1:0] m1_nr, m1_ng, m1_nb, m1_top, m1_low;
  branch_t           m1_br;
  logic [CHAN_W-1:0] top_c, low_c;
  branch_t           br_c;

  always_comb begin
    top_c = nr;
    low_c = nr;
    if (ng > top_c) top_c = ng;
    if (nb > top_c) top_c = nb;
    if (ng < low_c) low_c = ng;
    if (nb < low_c) low_c = nb;
    priority if (nr >= ng && nr >= nb) br_c = BR_RED;
    else if (ng >= nb)                  br_c = BR_GREEN;
    else                                br_c = BR_BLUE;
  end

  // Stage M2: delta and signed difference for the branch
  logic              m2_valid;
  logic [CHAN_W-1:0] m2_top, m2_delta;
  logic [CHAN_W:0]   m2_diff;
  branch_t           m2_br;
  logic [CHAN_W:0]   diff_c;

  always_comb begin
    unique case (m1_br)
      BR_RED:   diff_c = (CHAN_W+1)'(m1_ng) - (CHAN_W+1)'(m1_nb);
      BR_GREEN: diff_c = (CHAN_W+1)'(m1_nb) - (CHAN_W+1)'(m1_nr);
      BR_BLUE:  diff_c = (CHAN_W+1)'(m1_nr) - (CHAN_W+1)'(m1_ng);
      default:  diff_c = '0;
    endcase
  end

  // Stage M3: magnitude and zero flags
  logic              m3_valid;
  logic [CHAN_W-1:0] m3_top, m3_delta, m3_mag;
  logic              m3_neg, m3_dzero, m3_tzero;
  branch_t           m3_br;

  // Stage M4: magnitude times sixty degrees, divider operands
  logic                 m4_valid;
  logic [PROD_W-1:0]    m4_prod;
  logic [CHAN_W-1:0]    m4_delta;
  logic [DIV_DEN_W-1:0] m4_hden, m4_sden;
  logic [DIV_SIDE_W-1:0] m4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= nr_valid && ng_valid && nb_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_nr    <= nr;
      m1_ng    <= ng;
      m1_nb    <= nb;
      m1_top   <= top_c;
      m1_low   <= low_c;
      m1_br    <= br_c;

      m2_top   <= m1_top;
      m2_delta <= m1_top - m1_low;
      m2_diff  <= diff_c;
      m2_br    <= m1_br;

      m3_top   <= m2_top;
      m3_delta <= m2_delta;
      m3_neg   <= m2_diff[CHAN_W];
      m3_mag   <= m2_diff[CHAN_W] ? CHAN_W'((CHAN_W+1)'(0) - m2_diff) : m2_diff[CHAN_W-1:0];
      m3_dzero <= m2_delta == '0;
      m3_tzero <= m2_top == '0;
      m3_br    <= m2_br;

      m4_prod  <= PROD_W'(m3_mag) * PROD_W'(HUE_SIXTY);
      m4_delta <= m3_delta;
      // Zero divisors only meet zero dividends; divide by one to get zero
      m4_hden  <= m3_dzero ? DIV_DEN_W'(1) : m3_delta;
      m4_sden  <= m3_tzero ? DIV_DEN_W'(1) : m3_top;
      m4_side  <= {m3_top, m3_br, m3_neg, m3_dzero};
    end
  end

  logic                  hq_valid, sq_valid;
  logic [DIV_Q_W-1:0]    hq, sq;
  logic [DIV_SIDE_W-1:0] hq_side, sq_side;

  rgbhsb_div u_div_hue (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m4_valid),
    .dividend  (DIV_NUM_W'(m4_prod)),
    .divisor   (m4_hden),
    .side_in   ('0),
    .out_valid (hq_valid),
    .quotient  (hq),
    .side_out  (hq_side)
  );

  rgbhsb_div u_div_sat (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m4_valid),
    .dividend  (DIV_NUM_W'({m4_delta, 16'd0})),
    .divisor   (m4_sden),
    .side_in   (m4_side),
    .out_valid (sq_valid),
    .quotient  (sq),
    .side_out  (sq_side)
  );

  // Stage F1: add branch offset to the signed sixty-degree part
  logic              f1_valid;
  logic [HUE_W:0]    f1_hue;
  logic [SAT_W-1:0]  f1_sat;
  logic [CHAN_W-1:0] f1_top;
  logic              f1_dzero;
  logic [HUE_W:0]    ofs_c;
  logic [HUE_W:0]    hq_c;
  branch_t           sd_br;
  logic              sd_neg;

  assign sd_br  = branch_t'(sq_side[3:2]);
  assign sd_neg = sq_side[1];
  assign hq_c   = (HUE_W+1)'(hq[HQ_W-1:0]);

  always_comb begin
    unique case (sd_br)
      BR_RED:   ofs_c = '0;
      BR_GREEN: ofs_c = HUE_GREEN_OFS;
      BR_BLUE:  ofs_c = HUE_BLUE_OFS;
      default:  ofs_c = '0;
    endcase
  end

  // Stage F2: wrap negative hue, force grey to zero
  logic              f2_valid;
  logic [HUE_W-1:0]  f2_hue;
  logic [SAT_W-1:0]  f2_sat;
  logic [CHAN_W-1:0] f2_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= sq_valid && hq_valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_hue   <= sd_neg ? ofs_c - hq_c : ofs_c + hq_c;
      f1_sat   <= sq[SAT_W-1:0];
      f1_top   <= sq_side[DIV_SIDE_W-1:4];
      f1_dzero <= sq_side[0];

      if (f1_dzero) begin
        f2_hue <= '0;
      end else if (f1_hue[HUE_W]) begin
        f2_hue <= HUE_W'(f1_hue + HUE_FULL);
      end else begin
        f2_hue <= f1_hue[HUE_W-1:0];
      end
      f2_sat <= f1_sat;
      f2_top <= f1_top;
    end
  end

  // Skid register: park a stalled result and hold the pipeline
  logic [HUE_W-1:0]  skid_hue;
  logic [SAT_W-1:0]  skid_sat;
  logic [CHAN_W-1:0] skid_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!res_stall) skid_full <= 1'b0;
    end else if (f2_valid && res_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_hue <= f2_hue;
      skid_sat <= f2_sat;
      skid_top <= f2_top;
    end
  end

  assign res_valid        = skid_full || f2_valid;
  assign hue_degrees      = skid_full ? skid_hue : f2_hue;
  assign saturation_level = skid_full ? skid_sat : f2_sat;
  assign brightness_level = skid_full ? skid_top : f2_top;

endmodule

>>> design/rgbhsb_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module rgbhsb_div import rgbhsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DIV_NUM_W-1:0]  dividend,
  input  logic [DIV_DEN_W-1:0]  divisor,
  input  logic [DIV_SIDE_W-1:0] side_in,
  output logic                  out_valid,
  output logic [DIV_Q_W-1:0]    quotient,
  output logic [DIV_SIDE_W-1:0] side_out
);

  logic [DIV_STEPS-1:0]  vld;
  logic [DIV_DEN_W-1:0]  rem      [DIV_STEPS];
  logic [DIV_Q_W-1:0]    shq      [DIV_STEPS];
  logic [DIV_DEN_W-1:0]  den      [DIV_STEPS];
  logic [DIV_SIDE_W-1:0] side     [DIV_STEPS];
  logic [DIV_DEN_W-1:0]  rem_next [DIV_STEPS];
  logic [DIV_Q_W-1:0]    shq_next [DIV_STEPS];

  genvar s;
  for (s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DIV_DEN_W-1:0]  r_in;
    logic [DIV_Q_W-1:0]    w_in;
    logic [DIV_DEN_W-1:0]  d_in;
    logic [DIV_SIDE_W-1:0] s_in;
    logic [DIV_DEN_W:0]    trial;
    logic                  ge;

    if (s == 0) begin : g_first
      assign r_in = dividend[DIV_NUM_W-1:DIV_Q_W];
      assign w_in = dividend[DIV_Q_W-1:0];
      assign d_in = divisor;
      assign s_in = side_in;
    end else begin : g_rest
      assign r_in = rem[s-1];
      assign w_in = shq[s-1];
      assign d_in = den[s-1];
      assign s_in = side[s-1];
    end

    // Bring down the next dividend bit, subtract when it fits
    assign trial = {r_in, w_in[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign rem_next[s] = ge ? DIV_DEN_W'(trial - {1'b0, d_in}) : trial[DIV_DEN_W-1:0];
    assign shq_next[s] = {w_in[DIV_Q_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= rem_next[s];
        shq[s]  <= shq_next[s];
        den[s]  <= d_in;
        side[s] <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign quotient  = shq[DIV_STEPS-1];
  assign side_out  = side[DIV_STEPS-1];

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the RGB to hue/saturation/brightness conversion core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbhsb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int RANDOM_PHASES = 9;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [CHAN_W-1:0] bright;
  } hsb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] rgb;
    logic              known;
    hsb_t              want;
  } pixel_row_t;

  localparam int N_DIRECTED = 23;
  localparam pixel_row_t DIRECTED_PIXELS [N_DIRECTED] = '{
    '{24'h000000, 1'b1, '{16'd0,     17'd0,     24'd0}},
    '{24'hFFFFFF, 1'b1, '{16'd0,     17'd0,     24'd65536}},
    '{24'hFF0000, 1'b1, '{16'd0,     17'd65536, 24'd65536}},
    '{24'h00FF00, 1'b1, '{16'd15360, 17'd65536, 24'd65536}},
    '{24'h0000FF, 1'b1, '{16'd30720, 17'd65536, 24'd65536}},
    '{24'hFFFF00, 1'b1, '{16'd7680,  17'd65536, 24'd65536}},
    '{24'h00FFFF, 1'b1, '{16'd23040, 17'd65536, 24'd65536}},
    '{24'hFF00FF, 1'b1, '{16'd38400, 17'd65536, 24'd65536}},
    '{24'h808080, 1'b0, '0},
    '{24'h010101, 1'b0, '0},
    '{24'h010000, 1'b0, '0},
    '{24'h000001, 1'b0, '0},
    '{24'hFF0080, 1'b0, '0},
    '{24'hFF8000, 1'b0, '0},
    '{24'h80FF00, 1'b0, '0},
    '{24'h00FF80, 1'b0, '0},
    '{24'h8000FF, 1'b0, '0},
    '{24'h0080FF, 1'b0, '0},
    '{24'hFEFEFF, 1'b0, '0},
    '{24'hFFFEFE, 1'b0, '0},
    '{24'h7F7F80, 1'b0, '0},
    '{24'hAA55AA, 1'b0, '0},
    '{24'hFF7F7F, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  logic [CHAN_W-1:0]    rgb_color = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [HUE_W-1:0]     hue_degrees;
  logic [SAT_W-1:0]     saturation_level;
  logic [CHAN_W-1:0]    brightness_level;

  logic [CFG_W-1:0] red_max = CHAN_MAX_RESET;
  logic [CFG_W-1:0] green_max = CHAN_MAX_RESET;
  logic [CFG_W-1:0] blue_max = CHAN_MAX_RESET;

  hsb_t pending_hsb[$];
  hsb_t oldest_hsb;
  int   failures = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  rgb_to_hsb_convert_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pix_valid        (pix_valid),
    .pix_stall        (pix_stall),
    .rgb_color        (rgb_color),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .hue_degrees      (hue_degrees),
    .saturation_level (saturation_level),
    .brightness_level (brightness_level)
  );

  always #5 clk = ~clk;

  // byte * 65536 / max, a zero max divides by one
  function automatic logic [CHAN_W-1:0] scale_channel(input logic [7:0] level,
                                                      input logic [CFG_W-1:0] span);
    logic [31:0] num;
    logic [31:0] den;
    num = {8'd0, level, 16'd0};
    den = (span == '0) ? 32'd1 : {22'd0, span};
    return CHAN_W'(num / den);
  endfunction

  // diff * 60 degrees / delta, truncated toward zero
  function automatic int sixty_step(input longint diff, input logic [31:0] delta);
    longint mag;
    longint q;
    mag = (diff < 0) ? -diff : diff;
    q = (mag * longint'(HUE_SIXTY)) / longint'(delta);
    return (diff < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic hsb_t predict_hsb(input logic [CHAN_W-1:0] rgb);
    logic [31:0] nr;
    logic [31:0] ng;
    logic [31:0] nb;
    logic [31:0] top;
    logic [31:0] low;
    logic [31:0] delta;
    logic [63:0] sat;
    int          hue;
    hsb_t        r;
    nr = scale_channel(rgb[23:16], red_max);
    ng = scale_channel(rgb[15:8], green_max);
    nb = scale_channel(rgb[7:0], blue_max);
    top = nr;
    low = nr;
    if (ng > top) top = ng;
    if (nb > top) top = nb;
    if (ng < low) low = ng;
    if (nb < low) low = nb;
    delta = top - low;
    sat = (top == 0) ? 64'd0 : ({32'd0, delta} << 16) / {32'd0, top};
    if (delta == 0) begin
      hue = 0;
    end else if (top == nr) begin
      hue = sixty_step(longint'(ng) - longint'(nb), delta);
    end else if (top == ng) begin
      hue = int'(HUE_GREEN_OFS) + sixty_step(longint'(nb) - longint'(nr), delta);
    end else begin
      hue = int'(HUE_BLUE_OFS) + sixty_step(longint'(nr) - longint'(ng), delta);
    end
    if (hue < 0) hue += int'(HUE_FULL);
    r.hue = hue[HUE_W-1:0];
    r.sat = sat[SAT_W-1:0];
    r.bright = top[CHAN_W-1:0];
    return r;
  endfunction

  // mix of plain random colors, greys, ties, saturated edges and near-black
  function automatic logic [CHAN_W-1:0] random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         kind;
    kind = $urandom_range(9);
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    case (kind)
      5: begin
        g = r;
        b = r;
      end
      6: begin
        if ($urandom_range(1) == 0) g = r;
        else b = g;
      end
      7: begin
        r = ($urandom_range(2) == 0) ? 8'h00 : (($urandom_range(1) == 0) ? 8'hFF : r);
        g = ($urandom_range(2) == 0) ? 8'h00 : (($urandom_range(1) == 0) ? 8'hFF : g);
        b = ($urandom_range(2) == 0) ? 8'h00 : (($urandom_range(1) == 0) ? 8'hFF : b);
      end
      8: begin
        r = 8'($urandom_range(3));
        g = 8'($urandom_range(3));
        b = 8'($urandom_range(3));
      end
      9: begin
        g = r + 8'($urandom_range(1));
        b = r - 8'($urandom_range(1));
      end
      default: ;
    endcase
    return {r, g, b};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_RED_MAX:   red_max = val;
      CFG_GREEN_MAX: green_max = val;
      CFG_BLUE_MAX:  blue_max = val;
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [CHAN_W-1:0] rgb, input logic known,
                            input hsb_t want);
    pix_valid <= 1'b1;
    rgb_color <= rgb;
    @(negedge clk);
    while (pix_stall) @(negedge clk);
    @(posedge clk);
    pending_hsb.push_back(known ? want : predict_hsb(rgb));
    while ($urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (pending_hsb.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // sample mid-cycle: the result is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_hsb.size() == 0) begin
        $error("unexpected result: hue %0d sat %0d bright %0d",
               hue_degrees, saturation_level, brightness_level);
        failures++;
      end else begin
        oldest_hsb = pending_hsb.pop_front();
        if (hue_degrees !== oldest_hsb.hue) begin
          $error("hue_degrees: expected %0d, actual %0d", oldest_hsb.hue, hue_degrees);
          failures++;
        end
        if (saturation_level !== oldest_hsb.sat) begin
          $error("saturation_level: expected %0d, actual %0d",
                 oldest_hsb.sat, saturation_level);
          failures++;
        end
        if (brightness_level !== oldest_hsb.bright) begin
          $error("brightness_level: expected %0d, actual %0d",
                 oldest_hsb.bright, brightness_level);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_PIXELS[i]) begin
      send_pixel(DIRECTED_PIXELS[i].rgb, DIRECTED_PIXELS[i].known, DIRECTED_PIXELS[i].want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(CFG_RED_MAX, 10'd1023);
          write_reg(CFG_GREEN_MAX, 10'd1023);
          write_reg(CFG_BLUE_MAX, 10'd1023);
        end
        1: begin
          write_reg(CFG_RED_MAX, 10'd1);
          write_reg(CFG_GREEN_MAX, 10'd1);
          write_reg(CFG_BLUE_MAX, 10'd1);
        end
        2: begin
          // zero max behaves as one
          write_reg(CFG_RED_MAX, 10'd0);
          write_reg(CFG_GREEN_MAX, 10'd0);
          write_reg(CFG_BLUE_MAX, 10'd0);
          write_reg(CFG_UNUSED_IDX, 10'd1023);
        end
        3: begin
          write_reg(CFG_RED_MAX, 10'd1);
          write_reg(CFG_GREEN_MAX, 10'd1023);
          write_reg(CFG_BLUE_MAX, CHAN_MAX_RESET);
        end
        default: begin
          write_reg(CFG_RED_MAX, CFG_W'($urandom_range(1023, 1)));
          write_reg(CFG_GREEN_MAX, CFG_W'($urandom_range(1023, 1)));
          write_reg(CFG_BLUE_MAX, CFG_W'($urandom_range(1023, 1)));
          write_reg(CFG_UNUSED_IDX, CFG_W'($urandom));
        end
      endcase
      cfg_valid <= 1'b0;

      case (phase % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 56;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 56;
        end
        default: begin
          gap_pct = 31;
          stall_pct <= 31;
        end
      endcase

      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel(), 1'b0, '0);
    end

    drain();
    // catch any result beyond the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
